### sv/rc4_pkg.sv
// ----------------------------------------------------------------------------
// RC4 package
// Shared byte type, table geometry and key byte selection.
// ----------------------------------------------------------------------------
package rc4_pkg;

  localparam int RC4_DEPTH = 256;
  localparam int RC4_AW    = 8;
  localparam int RC4_KEY_W = 64;

  typedef logic [7:0] rc4_byte_t;

  function automatic rc4_byte_t key_byte(input logic [RC4_KEY_W-1:0] key,
                                         input logic [2:0] k);
    key_byte = key[{k, 3'b000} +: 8];
  endfunction

endpackage

### sv/rc4_stream_cipher.sv
// Each beat: IDLE (accept), BYTE_RD_I, BYTE_RD_J, BYTE_WR_I, BYTE_WR_J, BYTE_OUT,
// which holds while the output is stalled; the next beat is taken only in IDLE.
// A message's first beat waits for FILL and MIX_RD_N to MIX_WR_J over 256 entries.
// One one-read, one-write permutation RAM serves every swap and keystream access.
// Reset: clears indices, key and output valid, arms the key schedule;
// table contents are rebuilt by the schedule at each message start.
// ----------------------------------------------------------------------------
// RC4 stream cipher
// Byte-serial RC4 with 64-bit key and per-message key schedule.
// ----------------------------------------------------------------------------
module rc4_stream_cipher (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_data,   // cipher_key
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] data_in
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,    // [7:0] data_out
  output logic        m_tlast
);

  typedef enum logic [3:0] {
    IDLE, FILL,
    MIX_RD_N, MIX_RD_J, MIX_WR_N, MIX_WR_J,
    BYTE_RD_I, BYTE_RD_J, BYTE_WR_I, BYTE_WR_J, BYTE_OUT
  } state_t;

  state_t state;
  logic [rc4_pkg::RC4_KEY_W-1:0] key;
  logic pending;
  rc4_pkg::rc4_byte_t i, j, n, mk, sa, sb, data;
  logic last, hit;

  logic we, re;
  logic [rc4_pkg::RC4_AW-1:0] waddr, raddr;
  rc4_pkg::rc4_byte_t wdata, q, add_a, add_b, sum, ks;

  rc4_ram #(.WIDTH(8), .DEPTH(rc4_pkg::RC4_DEPTH)) u_ram (
    .clk, .we, .waddr, .wdata, .re, .raddr, .rdata(q)
  );

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == IDLE);
  assign sum       = add_a + add_b;
  assign ks        = hit ? sa : q;

  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = n;
    wdata = n;
    raddr = n;
    add_a = j;
    add_b = '0;
    unique case (state)
      FILL: begin
        we = 1'b1;
      end
      MIX_RD_N: begin
        re    = 1'b1;
        add_b = rc4_pkg::key_byte(key, n[2:0]);
      end
      MIX_RD_J: begin
        add_a = mk;
        add_b = q;
        re    = 1'b1;
        raddr = sum;
      end
      MIX_WR_N: begin
        we    = 1'b1;
        wdata = q;
      end
      MIX_WR_J: begin
        we    = 1'b1;
        waddr = j;
        wdata = sa;
      end
      BYTE_RD_I: begin
        add_a = i;
        add_b = 8'd1;
        re    = 1'b1;
        raddr = sum;
      end
      BYTE_RD_J: begin
        add_b = q;
        re    = 1'b1;
        raddr = sum;
      end
      BYTE_WR_I: begin
        we    = 1'b1;
        waddr = i;
        wdata = q;
      end
      BYTE_WR_J: begin
        we    = 1'b1;
        waddr = j;
        wdata = sa;
        add_a = sa;
        add_b = sb;
        re    = 1'b1;
        raddr = sum;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      key      <= '0;
      pending  <= 1'b1;
      i        <= '0;
      j        <= '0;
      n        <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        key <= cfg_data;
      end
      if (m_tvalid && m_tready && (state != BYTE_OUT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (s_tvalid) begin
            data  <= s_tdata;
            last  <= s_tlast;
            n     <= '0;
            state <= pending ? FILL : BYTE_RD_I;
            if (pending) begin
              j <= '0;
            end
          end
        end
        FILL: begin
          n <= n + 8'd1;
          if (n == 8'hFF) begin
            state <= MIX_RD_N;
          end
        end
        MIX_RD_N: begin
          mk    <= sum;
          state <= MIX_RD_J;
        end
        MIX_RD_J: begin
          sa    <= q;
          j     <= sum;
          state <= MIX_WR_N;
        end
        MIX_WR_N: begin
          state <= MIX_WR_J;
        end
        MIX_WR_J: begin
          n <= n + 8'd1;
          if (n == 8'hFF) begin
            i       <= '0;
            j       <= '0;
            pending <= 1'b0;
            state   <= BYTE_RD_I;
          end else begin
            state <= MIX_RD_N;
          end
        end
        BYTE_RD_I: begin
          i     <= sum;
          state <= BYTE_RD_J;
        end
        BYTE_RD_J: begin
          sa    <= q;
          j     <= sum;
          state <= BYTE_WR_I;
        end
        BYTE_WR_I: begin
          sb    <= q;
          state <= BYTE_WR_J;
        end
        BYTE_WR_J: begin
          hit   <= (sum == j);
          state <= BYTE_OUT;
        end
        BYTE_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= data ^ ks;
            m_tlast  <= last;
            m_tvalid <= 1'b1;
            pending  <= last;
            state    <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

### sv/rc4_ram.sv
// ----------------------------------------------------------------------------
// RC4 RAM
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/rc4_checker.sv
// ----------------------------------------------------------------------------
// RC4 checker
// Port-level properties of the RC4 stream cipher, bound to the top level.
// ----------------------------------------------------------------------------
module rc4_checker (
  input logic               clk,
  input logic               rst,
  input logic               s_tvalid,
  input logic               s_tready,
  input logic               m_tvalid,
  input logic               m_tready,
  input rc4_pkg::rc4_byte_t m_tdata,
  input logic               m_tlast
);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output beat changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready ##1 !s_tready ##1 !s_tready ##1 !s_tready)
    else $error("input accepted while busy");

  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !$rose(m_tvalid) ##1 !$rose(m_tvalid)
      ##1 !$rose(m_tvalid) ##1 !$rose(m_tvalid))
    else $error("result appeared too early");

endmodule

bind rc4_stream_cipher rc4_checker u_rc4_checker (.*);

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// RC4 stream cipher testbench
// Streams byte messages through the cipher under changing keys. Every input
// beat is run through a behavioral RC4 predictor and checked against the
// output beat. Keys change only when the block is idle, including in the
// middle of a message, and both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

  localparam int RANDOM_BEATS = 1650;
  localparam int STALL_LIMIT  = 8000;
  localparam int HOLD_CYCLES  = 600;
  localparam int MAX_WAIT     = 13;

  typedef struct packed {
    rc4_pkg::rc4_byte_t data;
    logic               last;
  } cipher_beat_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [rc4_pkg::RC4_KEY_W-1:0] cfg_data = '0;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [7:0]                    s_tdata = '0;
  logic                          s_tlast = 1'b0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [7:0]                    m_tdata;
  logic                          m_tlast;

  rc4_stream_cipher i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  rc4_pkg::rc4_byte_t            perm [rc4_pkg::RC4_DEPTH];
  rc4_pkg::rc4_byte_t            idx_i = '0;
  rc4_pkg::rc4_byte_t            idx_j = '0;
  bit                            rekey_due = 1'b1;
  logic [rc4_pkg::RC4_KEY_W-1:0] key_model = '0;

  cipher_beat_t plain_q [$];
  cipher_beat_t cipher_out_q [$];
  cipher_beat_t in_beat, out_beat, want;

  int  n_issued = 0;
  int  n_accepted = 0;
  int  n_results = 0;
  int  n_msgs = 0;
  int  n_keys = 0;
  int  n_errors = 0;
  int  stall_cycles = 0;
  int  tx_wait = 0;
  int  rx_wait = 0;
  int  rx_hold_cycles = 0;
  bit  tx_idle_on = 1'b0;
  bit  rx_idle_on = 1'b0;

  function automatic void rekey_perm();
    rc4_pkg::rc4_byte_t mix, t;
    mix = '0;
    for (int n = 0; n < rc4_pkg::RC4_DEPTH; n++) perm[n] = n[7:0];
    for (int n = 0; n < rc4_pkg::RC4_DEPTH; n++) begin
      mix = mix + perm[n] + key_model[8*(n%8) +: 8];
      t = perm[n];
      perm[n] = perm[mix];
      perm[mix] = t;
    end
    idx_i = '0;
    idx_j = '0;
  endfunction

  function automatic rc4_pkg::rc4_byte_t cipher_byte(rc4_pkg::rc4_byte_t din, logic last);
    rc4_pkg::rc4_byte_t t, ks;
    if (rekey_due) begin
      rekey_perm();
      rekey_due = 1'b0;
    end
    idx_i = idx_i + 8'd1;
    idx_j = idx_j + perm[idx_i];
    t = perm[idx_i];
    perm[idx_i] = perm[idx_j];
    perm[idx_j] = t;
    ks = perm[rc4_pkg::rc4_byte_t'(perm[idx_i] + perm[idx_j])];
    if (last) rekey_due = 1'b1;
    return din ^ ks;
  endfunction

  task automatic report_mismatch(string msg);
    n_errors++;
    if (n_errors <= 100) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  task automatic push_beat(rc4_pkg::rc4_byte_t d, logic l);
    cipher_beat_t b;
    b.data = d;
    b.last = l;
    plain_q.push_back(b);
    n_issued++;
    if (l) n_msgs++;
  endtask

  task automatic queue_message(int len, bit closed);
    for (int k = 0; k < len; k++)
      push_beat(rc4_pkg::rc4_byte_t'($urandom_range(0, 255)),
                closed && (k == len - 1));
  endtask

  task automatic load_key(logic [rc4_pkg::RC4_KEY_W-1:0] k);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= k;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    key_model = k;
    n_keys++;
  endtask

  task automatic wait_idle();
    while (n_issued != n_accepted || cipher_out_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // sender: hold each beat until taken, wait a drawn gap before the next
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        out_beat.data = cipher_byte(s_tdata, s_tlast);
        out_beat.last = s_tlast;
        cipher_out_q.push_back(out_beat);
        n_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (tx_wait > 0) begin
          tx_wait--;
          s_tvalid <= 1'b0;
        end else if (plain_q.size() != 0) begin
          in_beat = plain_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= in_beat.data;
          s_tlast  <= in_beat.last;
          tx_wait = tx_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: check each beat, then stall for a drawn number of cycles
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        n_results++;
        if (cipher_out_q.size() == 0) begin
          report_mismatch($sformatf("output beat data=%02h last=%0b with nothing pending",
                                    m_tdata, m_tlast));
        end else begin
          want = cipher_out_q.pop_front();
          if (m_tdata !== want.data)
            report_mismatch($sformatf("beat %0d data got %02h want %02h",
                                      n_results, m_tdata, want.data));
          if (m_tlast !== want.last)
            report_mismatch($sformatf("beat %0d last got %0b want %0b",
                                      n_results, m_tlast, want.last));
        end
        rx_wait = rx_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
      end
      if (rx_hold_cycles > 0) begin
        rx_hold_cycles--;
        m_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int                            phase;
    int                            n_parts;
    int                            len;
    int                            pick;
    int                            random_start;
    bit                            leave_open;
    logic [rc4_pkg::RC4_KEY_W-1:0] key;

    phase = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero key, byte extremes, single-byte messages
    load_key('0);
    push_beat(8'h00, 1'b0);
    push_beat(8'hFF, 1'b0);
    push_beat(8'h55, 1'b0);
    push_beat(8'hAA, 1'b1);
    push_beat(8'h80, 1'b1);
    push_beat(8'h01, 1'b1);
    wait_idle();

    // all-ones key, then a key change in the middle of an open message
    load_key('1);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    push_beat(8'h7F, 1'b0);
    push_beat(8'hFE, 1'b0);
    push_beat(8'h00, 1'b0);
    wait_idle();
    load_key(64'h0123_4567_89AB_CDEF);
    push_beat(8'hFF, 1'b0);
    push_beat(8'h3C, 1'b0);
    push_beat(8'hC3, 1'b1);
    push_beat(8'h00, 1'b0);
    push_beat(8'hFF, 1'b1);
    wait_idle();

    random_start = n_issued;
    while (n_issued - random_start < RANDOM_BEATS) begin
      phase++;
      if ($urandom_range(0, 3) != 0) begin
        pick = $urandom_range(0, 9);
        case (pick)
          0:       key = '0;
          1:       key = '1;
          2:       key = 64'hAAAA_AAAA_AAAA_AAAA;
          default: key = {$urandom, $urandom};
        endcase
        load_key(key);
      end
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      // long receiver hold while the sender keeps offering beats
      if (phase == 3) begin
        tx_idle_on = 1'b0;
        rx_hold_cycles = HOLD_CYCLES;
      end
      n_parts = $urandom_range(2, 6);
      leave_open = ($urandom_range(0, 1) == 1);
      for (int m = 0; m < n_parts; m++) begin
        pick = $urandom_range(0, 19);
        if (pick == 0)     len = $urandom_range(200, 320);
        else if (pick < 5) len = 1;
        else               len = $urandom_range(2, 30);
        queue_message(len, !(leave_open && m == n_parts - 1));
      end
      wait_idle();
    end

    $display("Covered %0d beats in %0d closed messages across %0d key loads;",
             n_issued, n_msgs, n_keys);
    $display("checked %0d output beats, with one long output stall and mid-message rekeys.",
             n_results);
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
